@@ hdl/fcgc_pkg.sv @@
// fcgc_pkg: shared types and constants for the front corridor guarded creep block.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package fcgc_pkg;

  // command codes carried in tuser
  typedef enum logic [1:0] {
    CMD_POINT = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_START = 2'd2,
    CMD_HALT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RUNNING = 2'd1,
    ST_SUCCESS = 2'd2,
    ST_FAILURE = 2'd3
  } status_t;

  // register indexes (byte address 4*index)
  localparam int unsigned REG_SAFETY_ENABLE = 0;
  localparam int unsigned REG_STOP_DISTANCE = 1;
  localparam int unsigned REG_HALF_WIDTH    = 2;
  localparam int unsigned REG_MIN_POINTS    = 3;
  localparam int unsigned REG_CLOUD_TIMEOUT = 4;
  localparam int unsigned REG_FWD_SPEED     = 5;
  localparam int unsigned REG_FWD_DURATION  = 6;

  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned IDX_BITS  = 3;

  // corridor bounds in mm, exclusive
  localparam int CORR_X_MIN = 200;
  localparam int CORR_Z_MIN = -150;
  localparam int CORR_Z_MAX = 1700;

  localparam int unsigned AGE_BITS   = 17;
  localparam int unsigned TICK_BITS  = 16;
  localparam int unsigned COUNT_BITS = 10;
  localparam int unsigned SPEED_BITS = 12;
  localparam int unsigned DIST_BITS  = 15;

  localparam logic [AGE_BITS-1:0]   AGE_MAX   = '1;
  localparam logic [TICK_BITS-1:0]  TICKS_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // register reset values
  localparam logic                  RST_SAFETY   = 1'b1;
  localparam logic [DIST_BITS-1:0]  RST_STOP     = 15'd450;
  localparam logic [DIST_BITS-1:0]  RST_HALF_W   = 15'd180;
  localparam logic [COUNT_BITS-1:0] RST_MIN_PTS  = 10'd4;
  localparam logic [TICK_BITS-1:0]  RST_TIMEOUT  = 16'd500;
  localparam logic [SPEED_BITS-1:0] RST_SPEED    = 12'd80;
  localparam logic [TICK_BITS-1:0]  RST_DURATION = 16'd1500;

  typedef struct packed {
    logic                  safety_enable;
    logic [DIST_BITS-1:0]  stop_distance_mm;
    logic [DIST_BITS-1:0]  half_width_mm;
    logic [COUNT_BITS-1:0] min_points;
    logic [TICK_BITS-1:0]  cloud_timeout_ms;
    logic [SPEED_BITS-1:0] forward_speed;
    logic [TICK_BITS-1:0]  forward_duration_ms;
  } cfg_t;

  // classified word held between front and back
  typedef struct packed {
    cmd_t cmd;
    logic in_corr;
    logic last_point;
  } entry_t;

endpackage

@@ hdl/fcgc_front.sv @@
// fcgc_front: classifies an incoming word, doing the corridor box test on points.
// Depends on fcgc_pkg.
`timescale 1ns / 1ps

module fcgc_front #(
  parameter int COORD_BITS = 16
) (
  input  fcgc_pkg::cfg_t          cfg,
  input  logic [1:0]              command,
  input  logic [COORD_BITS-1:0]   x_mm,
  input  logic [COORD_BITS-1:0]   y_mm,
  input  logic [COORD_BITS-1:0]   z_mm,
  input  logic                    last_point,
  output fcgc_pkg::entry_t        entry
);

  // common compare width: room for the 15-bit limits and their negation
  localparam int CW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 1;

  logic signed [CW-1:0] xs, ys, zs, stop_s, hw_s, hw_neg;
  logic                 x_ok, y_ok, z_ok;

  assign xs     = CW'($signed(x_mm));
  assign ys     = CW'($signed(y_mm));
  assign zs     = CW'($signed(z_mm));
  assign stop_s = $signed(CW'(cfg.stop_distance_mm));
  assign hw_s   = $signed(CW'(cfg.half_width_mm));
  assign hw_neg = -hw_s;

  assign x_ok = (xs > CW'(fcgc_pkg::CORR_X_MIN)) && (xs < stop_s);
  assign y_ok = (ys < hw_s) && (ys > hw_neg);
  assign z_ok = (zs > CW'(fcgc_pkg::CORR_Z_MIN)) && (zs < CW'(fcgc_pkg::CORR_Z_MAX));

  assign entry.cmd        = fcgc_pkg::cmd_t'(command);
  assign entry.in_corr    = x_ok && y_ok && z_ok;
  assign entry.last_point = last_point;

endmodule

@@ hdl/fcgc_queue.sv @@
// fcgc_queue: small register FIFO of classified words between front and back.
// Depends on fcgc_pkg.
`timescale 1ns / 1ps

module fcgc_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fcgc_pkg::entry_t wr_entry,
  input  logic             pop,
  output fcgc_pkg::entry_t rd_entry,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fcgc_pkg::entry_t mem_r [DEPTH];
  logic [AW:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;

  // top pointer bit is a lap flag: same index on different laps means full
  assign full  = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                 (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign empty = (wr_ptr_r == rd_ptr_r);
  assign rd_entry = mem_r[rd_ptr_r[AW-1:0]];

  // pointers wrap at DEPTH so non power-of-two depths also work
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
      if (wr_ptr_nxt[AW-1:0] == AW'(DEPTH)) begin
        wr_ptr_nxt = {~wr_ptr_r[AW], {AW{1'b0}}};
      end
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
      if (rd_ptr_nxt[AW-1:0] == AW'(DEPTH)) begin
        rd_ptr_nxt = {~rd_ptr_r[AW], {AW{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r[AW-1:0]] <= wr_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("queue read while empty");

endmodule

@@ hdl/fcgc_back.sv @@
// fcgc_back: cloud tracking, motion sequencing and the output register.
// Depends on fcgc_pkg.
`timescale 1ns / 1ps

module fcgc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fcgc_pkg::cfg_t                cfg,
  input  fcgc_pkg::entry_t              entry,
  input  logic                          entry_valid,
  output logic                          entry_pop,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [fcgc_pkg::SPEED_BITS-1:0] res_drive,
  output fcgc_pkg::status_t             res_status,
  output logic                          res_blocked
);

  logic                              running_r, running_nxt;
  logic [fcgc_pkg::TICK_BITS-1:0]    ticks_r, ticks_nxt;
  logic [fcgc_pkg::AGE_BITS-1:0]     age_r, age_nxt;
  logic                              seen_r, seen_nxt;
  logic                              in_cloud_r, in_cloud_nxt;
  logic                              decided_r, decided_nxt;
  logic [fcgc_pkg::COUNT_BITS-1:0]   count_r, count_nxt;
  logic                              flag_r, flag_nxt;
  logic [fcgc_pkg::SPEED_BITS-1:0]   hold_r, hold_nxt;
  fcgc_pkg::status_t                 status_nxt;
  logic                              blocked_nxt;

  logic                              out_valid_r;
  logic [fcgc_pkg::SPEED_BITS-1:0]   out_drive_r;
  fcgc_pkg::status_t                 out_status_r;
  logic                              out_blocked_r;

  assign entry_pop   = entry_valid && (!out_valid_r || res_ready);
  assign res_valid   = out_valid_r;
  assign res_drive   = out_drive_r;
  assign res_status  = out_status_r;
  assign res_blocked = out_blocked_r;

  always_comb begin
    logic blk;
    running_nxt  = running_r;
    ticks_nxt    = ticks_r;
    age_nxt      = age_r;
    seen_nxt     = seen_r;
    in_cloud_nxt = in_cloud_r;
    decided_nxt  = decided_r;
    count_nxt    = count_r;
    flag_nxt     = flag_r;
    hold_nxt     = hold_r;
    status_nxt   = fcgc_pkg::ST_IDLE;
    blk          = 1'b0;

    unique case (entry.cmd)
      fcgc_pkg::CMD_POINT: begin
        if (!in_cloud_r) begin
          in_cloud_nxt = 1'b1;
          seen_nxt     = 1'b1;
          age_nxt      = '0;
          decided_nxt  = 1'b0;
          count_nxt    = '0;
        end
        if (!cfg.safety_enable) begin
          flag_nxt    = 1'b0;
          decided_nxt = 1'b1;
        end
        if (!decided_nxt && entry.in_corr) begin
          if (count_nxt != fcgc_pkg::COUNT_MAX) begin
            count_nxt = count_nxt + 1'b1;
          end
          if (count_nxt >= cfg.min_points) begin
            flag_nxt    = 1'b1;
            decided_nxt = 1'b1;
          end
        end
        if (entry.last_point) begin
          if (!decided_nxt) begin
            flag_nxt = 1'b0;
          end
          in_cloud_nxt = 1'b0;
        end
      end
      fcgc_pkg::CMD_TICK: begin
        if (age_r != fcgc_pkg::AGE_MAX) begin
          age_nxt = age_r + 1'b1;
        end
        // guard uses the aged cloud
        blk = cfg.safety_enable && (!seen_r || flag_r ||
              (age_nxt > {1'b0, cfg.cloud_timeout_ms}));
        if (running_r) begin
          if (blk) begin
            hold_nxt   = '0;
            status_nxt = fcgc_pkg::ST_RUNNING;
          end else begin
            if (ticks_r != fcgc_pkg::TICKS_MAX) begin
              ticks_nxt = ticks_r + 1'b1;
            end
            hold_nxt = cfg.forward_speed;
            if (ticks_nxt >= cfg.forward_duration_ms) begin
              running_nxt = 1'b0;
              status_nxt  = fcgc_pkg::ST_SUCCESS;
            end else begin
              status_nxt  = fcgc_pkg::ST_RUNNING;
            end
          end
        end
      end
      fcgc_pkg::CMD_START: begin
        blk = cfg.safety_enable && (!seen_r || flag_r ||
              (age_r > {1'b0, cfg.cloud_timeout_ms}));
        if (cfg.forward_speed == '0 || cfg.forward_duration_ms == '0) begin
          running_nxt = 1'b0;
          hold_nxt    = '0;
          status_nxt  = fcgc_pkg::ST_FAILURE;
        end else begin
          running_nxt = 1'b1;
          ticks_nxt   = '0;
          hold_nxt    = blk ? '0 : cfg.forward_speed;
          status_nxt  = fcgc_pkg::ST_RUNNING;
        end
      end
      fcgc_pkg::CMD_HALT: begin
        running_nxt = 1'b0;
        hold_nxt    = '0;
        status_nxt  = fcgc_pkg::ST_IDLE;
      end
      default: begin
        status_nxt = fcgc_pkg::ST_IDLE;
      end
    endcase

    blocked_nxt = cfg.safety_enable && (!seen_nxt || flag_nxt ||
                  (age_nxt > {1'b0, cfg.cloud_timeout_ms}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      ticks_r     <= '0;
      age_r       <= '0;
      seen_r      <= 1'b0;
      in_cloud_r  <= 1'b0;
      decided_r   <= 1'b0;
      count_r     <= '0;
      flag_r      <= 1'b1;
      hold_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (entry_pop) begin
        running_r   <= running_nxt;
        ticks_r     <= ticks_nxt;
        age_r       <= age_nxt;
        seen_r      <= seen_nxt;
        in_cloud_r  <= in_cloud_nxt;
        decided_r   <= decided_nxt;
        count_r     <= count_nxt;
        flag_r      <= flag_nxt;
        hold_r      <= hold_nxt;
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (entry_pop) begin
      out_drive_r   <= hold_nxt;
      out_status_r  <= status_nxt;
      out_blocked_r <= blocked_nxt;
    end
  end

  a_success_stops: assert property (@(posedge clk) disable iff (!rst_n)
    entry_pop && status_nxt == fcgc_pkg::ST_SUCCESS |=> !running_r)
    else $error("motion still running after success");

  a_failure_zero: assert property (@(posedge clk) disable iff (!rst_n)
    entry_pop && status_nxt == fcgc_pkg::ST_FAILURE |=> hold_r == '0 && !running_r)
    else $error("failed start left drive or motion active");

  a_running_state: assert property (@(posedge clk) disable iff (!rst_n)
    entry_pop && status_nxt == fcgc_pkg::ST_RUNNING |=> running_r)
    else $error("running reported while motion stopped");

endmodule

@@ hdl/front_corridor_guarded_creep_core.sv @@
// Top level of the front corridor guarded creep block: register file, front
// classifier, word queue and back end. Depends on fcgc_pkg and the fcgc_* modules.
//
//  channel  | ports                    | content
//  ---------+--------------------------+---------------------------------------
//  in       | in_tvalid/tready/tdata   | point/tick/start/halt words
//  out      | out_tvalid/tready/tdata  | drive speed, status, blocked per word
//  cfg      | cfg_psel ... cfg_prdata  | seven control registers at 4*index
//
// One result per input word, at most one word per cycle in each direction.
// Each word is classified into the queue, then its state update goes
// into the output register. The queue (QUEUE_DEPTH words) absorbs output stalls;
// in_tready drops only while it is full. Reset is synchronous, active low, and
// needs no clearing pass.
`timescale 1ns / 1ps

module front_corridor_guarded_creep_core #(
  parameter int COORD_BITS  = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: x_mm, y_mm, z_mm (COORD_BITS each, signed), zero padded
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  input  logic                                 in_tlast,
  // in_tuser: command [1:0]
  input  logic [1:0]                           in_tuser,
  // out_tdata: drive_speed [11:0], status [13:12], blocked [14], zero [15]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [15:0]                          out_tdata,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [fcgc_pkg::ADDR_BITS-1:0]       cfg_paddr,
  input  logic [31:0]                          cfg_pwdata,
  output logic [31:0]                          cfg_prdata,
  output logic                                 cfg_pready
);

  fcgc_pkg::cfg_t   cfg_r;
  fcgc_pkg::entry_t front_entry, head_entry;
  logic             q_full, q_empty, q_pop, q_push, wr_en;
  logic [fcgc_pkg::IDX_BITS-1:0] reg_idx;
  logic [fcgc_pkg::SPEED_BITS-1:0] res_drive;
  fcgc_pkg::status_t res_status;
  logic             res_blocked;

  // register file
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[fcgc_pkg::ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.safety_enable       <= fcgc_pkg::RST_SAFETY;
      cfg_r.stop_distance_mm    <= fcgc_pkg::RST_STOP;
      cfg_r.half_width_mm       <= fcgc_pkg::RST_HALF_W;
      cfg_r.min_points          <= fcgc_pkg::RST_MIN_PTS;
      cfg_r.cloud_timeout_ms    <= fcgc_pkg::RST_TIMEOUT;
      cfg_r.forward_speed       <= fcgc_pkg::RST_SPEED;
      cfg_r.forward_duration_ms <= fcgc_pkg::RST_DURATION;
    end else if (wr_en) begin
      unique case (reg_idx)
        fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_SAFETY_ENABLE):
          cfg_r.safety_enable <= cfg_pwdata[0];
        fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_STOP_DISTANCE):
          cfg_r.stop_distance_mm <= cfg_pwdata[fcgc_pkg::DIST_BITS-1:0];
        fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_HALF_WIDTH):
          cfg_r.half_width_mm <= cfg_pwdata[fcgc_pkg::DIST_BITS-1:0];
        fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_MIN_POINTS):
          cfg_r.min_points <= cfg_pwdata[fcgc_pkg::COUNT_BITS-1:0];
        fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_CLOUD_TIMEOUT):
          cfg_r.cloud_timeout_ms <= cfg_pwdata[fcgc_pkg::TICK_BITS-1:0];
        fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_FWD_SPEED):
          cfg_r.forward_speed <= cfg_pwdata[fcgc_pkg::SPEED_BITS-1:0];
        fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_FWD_DURATION):
          cfg_r.forward_duration_ms <= cfg_pwdata[fcgc_pkg::TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_SAFETY_ENABLE):
        cfg_prdata = 32'(cfg_r.safety_enable);
      fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_STOP_DISTANCE):
        cfg_prdata = 32'(cfg_r.stop_distance_mm);
      fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_HALF_WIDTH):
        cfg_prdata = 32'(cfg_r.half_width_mm);
      fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_MIN_POINTS):
        cfg_prdata = 32'(cfg_r.min_points);
      fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_CLOUD_TIMEOUT):
        cfg_prdata = 32'(cfg_r.cloud_timeout_ms);
      fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_FWD_SPEED):
        cfg_prdata = 32'(cfg_r.forward_speed);
      fcgc_pkg::IDX_BITS'(fcgc_pkg::REG_FWD_DURATION):
        cfg_prdata = 32'(cfg_r.forward_duration_ms);
      default:
        cfg_prdata = '0;
    endcase
  end

  fcgc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .cfg        (cfg_r),
    .command    (in_tuser),
    .x_mm       (in_tdata[COORD_BITS-1:0]),
    .y_mm       (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .z_mm       (in_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .last_point (in_tlast),
    .entry      (front_entry)
  );

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  fcgc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (front_entry),
    .pop      (q_pop),
    .rd_entry (head_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  fcgc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .entry       (head_entry),
    .entry_valid (!q_empty),
    .entry_pop   (q_pop),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_drive   (res_drive),
    .res_status  (res_status),
    .res_blocked (res_blocked)
  );

  assign out_tdata = {1'b0, res_blocked, res_status, res_drive};

endmodule
